>>> design/rsmp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package rsmp_pkg;

    localparam int SMP_W     = 16;
    localparam int COEF_W    = 16;
    localparam int CFG_W     = 6;
    localparam int DLY_W     = 5;
    localparam int IDX_W     = 2;
    localparam int HIST_AW   = 6;
    localparam int TAP_AW    = 5;
    localparam int PH_AW     = 5;
    localparam int COEF_AW   = PH_AW + TAP_AW;
    localparam int PROD_W    = SMP_W + COEF_W;
    localparam int ACC_W     = PROD_W + TAP_AW + 1;
    localparam int FRAC_BITS = 14;

    localparam logic [CFG_W-1:0] MAX_PHASES = CFG_W'(32);
    localparam logic [CFG_W-1:0] MAX_DECIM  = CFG_W'(32);
    localparam logic [CFG_W-1:0] MAX_TAPS   = CFG_W'(32);

    localparam logic [IDX_W-1:0] REG_INTERP = 2'd0;
    localparam logic [IDX_W-1:0] REG_DECIM  = 2'd1;
    localparam logic [IDX_W-1:0] REG_TAPS   = 2'd2;
    localparam logic [IDX_W-1:0] REG_DELAY  = 2'd3;

    localparam logic CMD_SAMPLE = 1'b0;
    localparam logic CMD_COEF   = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MAC,
        ST_DRAIN,
        ST_ROUND
    } t_state;

    typedef struct packed {
        logic clear;
        logic issue;
    } t_mac_ctl;

    typedef struct packed {
        logic              busy;
        logic              clip;
        logic [SMP_W-1:0]  re;
        logic [SMP_W-1:0]  im;
    } t_mac_res;

endpackage

`default_nettype wire

>>> design/polyphase_rational_resampler.sv
// Rational P/Q polyphase resampler for complex 16-bit samples with Q2.14
// coefficients. A coefficient beat (cmd 1) is written straight into the
// coefficient memory. For every output a sample beat produces, one shared
// complex multiply-accumulate unit runs one tap per cycle, fed by the
// registered reads of the history and coefficient memories; that pipeline
// then drains, and the rounded sum is loaded into the output register once
// the register is free. Input ready is held low until the last output of a
// sample has been placed in the output register; a finished output may wait
// there while the next beat is taken.
// Registers are written through a plain write port; the user must write them
// only while the block is idle, as the block itself does not enforce this.
`timescale 1ns / 1ps
`default_nettype none

module polyphase_rational_resampler (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic                                 i_cfg_we,
    input  wire logic [rsmp_pkg::IDX_W-1:0]           i_cfg_idx,
    input  wire logic [rsmp_pkg::CFG_W-1:0]           i_cfg_data,
    input  wire logic                                 i_in_valid,
    output logic                                      o_in_ready,
    input  wire logic                                 i_cmd,
    input  wire logic signed [rsmp_pkg::SMP_W-1:0]    i_sample_re,
    input  wire logic signed [rsmp_pkg::SMP_W-1:0]    i_sample_im,
    input  wire logic [rsmp_pkg::PH_AW-1:0]           i_coef_phase,
    input  wire logic [rsmp_pkg::TAP_AW-1:0]          i_coef_tap,
    input  wire logic signed [rsmp_pkg::COEF_W-1:0]   i_coef_value,
    output logic                                      o_out_valid,
    input  wire logic                                 i_out_ready,
    output logic signed [rsmp_pkg::SMP_W-1:0]         o_out_re,
    output logic signed [rsmp_pkg::SMP_W-1:0]         o_out_im,
    output logic                                      o_last_output,
    output logic                                      o_clipped
);
    import rsmp_pkg::*;

    t_state              r_state;
    t_state              n_state;
    logic [CFG_W-1:0]    r_interp;
    logic [CFG_W-1:0]    r_decim;
    logic [CFG_W-1:0]    r_taps;
    logic [DLY_W-1:0]    r_dly;
    logic [HIST_AW-1:0]  r_wp;
    logic [CFG_W-1:0]    r_phase;
    logic [CFG_W-1:0]    r_tap;
    logic                r_out_valid;
    logic [SMP_W-1:0]    r_out_re;
    logic [SMP_W-1:0]    r_out_im;
    logic                r_out_last;
    logic                r_out_clip;

    logic [CFG_W-1:0]    p_eff;
    logic [CFG_W-1:0]    q_eff;
    logic [CFG_W-1:0]    taps_eff;
    logic [CFG_W:0]      phase_sum;
    logic                in_acc;
    logic                smp_acc;
    logic                coef_acc;
    logic                out_free;
    logic                out_load;
    logic                more_out;
    logic                last_issue;
    t_mac_ctl            mac_ctl;
    t_mac_res            mac_res;
    logic [HIST_AW-1:0]  hist_raddr;
    logic [2*SMP_W-1:0]  hist_rdata;
    logic                hist_rok;
    logic [COEF_AW-1:0]  coef_raddr;
    logic [COEF_W-1:0]   coef_rdata;

    always_comb begin
        p_eff    = (r_interp == '0) ? CFG_W'(1) :
                   ((r_interp > MAX_PHASES) ? MAX_PHASES : r_interp);
        q_eff    = (r_decim == '0) ? CFG_W'(1) :
                   ((r_decim > MAX_DECIM) ? MAX_DECIM : r_decim);
        taps_eff = (r_taps == '0) ? CFG_W'(1) :
                   ((r_taps > MAX_TAPS) ? MAX_TAPS : r_taps);
    end

    assign in_acc     = i_in_valid && o_in_ready;
    assign smp_acc    = in_acc && (i_cmd == CMD_SAMPLE);
    assign coef_acc   = in_acc && (i_cmd == CMD_COEF);
    assign out_free   = !r_out_valid || i_out_ready;
    assign phase_sum  = {1'b0, r_phase} + {1'b0, q_eff};
    assign more_out   = phase_sum < {1'b0, p_eff};
    assign last_issue = r_tap == (taps_eff - CFG_W'(1));
    assign hist_raddr = r_wp - HIST_AW'(1) - (HIST_AW'(r_dly) + HIST_AW'(r_tap));
    assign coef_raddr = {r_phase[PH_AW-1:0], r_tap[TAP_AW-1:0]};

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (smp_acc && (r_phase < p_eff)) begin
                    n_state = ST_MAC;
                end
            end
            ST_MAC: begin
                if (last_issue) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (!mac_res.busy) begin
                    n_state = ST_ROUND;
                end
            end
            ST_ROUND: begin
                if (out_free) begin
                    n_state = more_out ? ST_MAC : ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready    = 1'b0;
        out_load      = 1'b0;
        mac_ctl.issue = 1'b0;
        mac_ctl.clear = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready    = 1'b1;
                mac_ctl.clear = smp_acc;
            end
            ST_MAC: begin
                mac_ctl.issue = 1'b1;
            end
            ST_DRAIN: begin
            end
            ST_ROUND: begin
                out_load      = out_free;
                mac_ctl.clear = out_free;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_interp    <= CFG_W'(1);
            r_decim     <= CFG_W'(1);
            r_taps      <= MAX_TAPS;
            r_dly       <= '0;
            r_wp        <= '0;
            r_phase     <= '0;
            r_tap       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_INTERP: r_interp <= i_cfg_data;
                    REG_DECIM:  r_decim  <= i_cfg_data;
                    REG_TAPS:   r_taps   <= i_cfg_data;
                    REG_DELAY:  r_dly    <= i_cfg_data[DLY_W-1:0];
                    default: begin
                    end
                endcase
            end
            if (smp_acc) begin
                r_wp <= r_wp + HIST_AW'(1);
                if (r_phase >= p_eff) begin
                    r_phase <= r_phase - p_eff;
                end
            end
            if (out_load) begin
                if (more_out) begin
                    r_phase <= phase_sum[CFG_W-1:0];
                end else begin
                    r_phase <= CFG_W'(phase_sum - {1'b0, p_eff});
                end
            end
            if (mac_ctl.clear) begin
                r_tap <= '0;
            end else if (mac_ctl.issue) begin
                r_tap <= r_tap + CFG_W'(1);
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_re   <= mac_res.re;
            r_out_im   <= mac_res.im;
            r_out_clip <= mac_res.clip;
            r_out_last <= !more_out;
        end
    end

    rsmp_hist_mem u_hist (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (smp_acc),
        .i_waddr (r_wp),
        .i_wdata ({i_sample_re, i_sample_im}),
        .i_raddr (hist_raddr),
        .o_rdata (hist_rdata),
        .o_rok   (hist_rok)
    );

    rsmp_coef_mem u_coef (
        .i_clk   (i_clk),
        .i_we    (coef_acc),
        .i_waddr ({i_coef_phase, i_coef_tap}),
        .i_wdata (i_coef_value),
        .i_raddr (coef_raddr),
        .o_rdata (coef_rdata)
    );

    rsmp_mac u_mac (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (mac_ctl),
        .i_coef    (coef_rdata),
        .i_hist    (hist_rdata),
        .i_hist_ok (hist_rok),
        .o_res     (mac_res)
    );

    assign o_out_valid   = r_out_valid;
    assign o_out_re      = r_out_re;
    assign o_out_im      = r_out_im;
    assign o_last_output = r_out_last;
    assign o_clipped     = r_out_clip;

`ifndef ASSERT_OFF
    a_busy_not_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mac_res.busy |-> !o_in_ready)
        else $error("mac pipeline busy while accepting input");

    a_load_after_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_load |-> !mac_res.busy)
        else $error("output loaded before accumulation finished");

    a_wp_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        smp_acc |=> r_wp == HIST_AW'($past(r_wp) + HIST_AW'(1)))
        else $error("history pointer did not advance on sample beat");
`endif

endmodule

`default_nettype wire

>>> design/rsmp_hist_mem.sv
`timescale 1ns / 1ps
`default_nettype none

module rsmp_hist_mem (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_we,
    input  wire logic [rsmp_pkg::HIST_AW-1:0]  i_waddr,
    input  wire logic [2*rsmp_pkg::SMP_W-1:0]  i_wdata,
    input  wire logic [rsmp_pkg::HIST_AW-1:0]  i_raddr,
    output logic      [2*rsmp_pkg::SMP_W-1:0]  o_rdata,
    output logic                               o_rok
);
    import rsmp_pkg::*;

    localparam int DEPTH = 2 ** HIST_AW;

    logic [2*SMP_W-1:0] r_mem [DEPTH];
    logic [DEPTH-1:0]   r_valid;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

    // entries never written since reset give o_rok low, so the MAC reads them as zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            o_rok   <= 1'b0;
        end else begin
            if (i_we) begin
                r_valid[i_waddr] <= 1'b1;
            end
            o_rok <= r_valid[i_raddr];
        end
    end

endmodule

`default_nettype wire

>>> design/rsmp_coef_mem.sv
`timescale 1ns / 1ps
`default_nettype none

module rsmp_coef_mem (
    input  wire logic                          i_clk,
    input  wire logic                          i_we,
    input  wire logic [rsmp_pkg::COEF_AW-1:0]  i_waddr,
    input  wire logic [rsmp_pkg::COEF_W-1:0]   i_wdata,
    input  wire logic [rsmp_pkg::COEF_AW-1:0]  i_raddr,
    output logic      [rsmp_pkg::COEF_W-1:0]   o_rdata
);
    import rsmp_pkg::*;

    localparam int DEPTH = 2 ** COEF_AW;

    logic [COEF_W-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

>>> design/rsmp_mac.sv
`timescale 1ns / 1ps
`default_nettype none

module rsmp_mac (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire rsmp_pkg::t_mac_ctl            i_ctl,
    input  wire logic [rsmp_pkg::COEF_W-1:0]   i_coef,
    input  wire logic [2*rsmp_pkg::SMP_W-1:0]  i_hist,
    input  wire logic                          i_hist_ok,
    output rsmp_pkg::t_mac_res                 o_res
);
    import rsmp_pkg::*;

    localparam int Q_W = ACC_W - FRAC_BITS;

    logic                     r_v1;
    logic                     r_v2;
    logic signed [PROD_W-1:0] r_prod_re;
    logic signed [PROD_W-1:0] r_prod_im;
    logic signed [ACC_W-1:0]  r_acc_re;
    logic signed [ACC_W-1:0]  r_acc_im;

    logic signed [SMP_W-1:0]  smp_re;
    logic signed [SMP_W-1:0]  smp_im;
    logic signed [ACC_W-1:0]  rnd_re;
    logic signed [ACC_W-1:0]  rnd_im;
    logic signed [Q_W-1:0]    q_re;
    logic signed [Q_W-1:0]    q_im;
    logic                     clip_re;
    logic                     clip_im;

    assign smp_re = i_hist_ok ? $signed(i_hist[2*SMP_W-1:SMP_W]) : '0;
    assign smp_im = i_hist_ok ? $signed(i_hist[SMP_W-1:0]) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            r_v1 <= i_ctl.issue;
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod_re <= $signed(i_coef) * smp_re;
        r_prod_im <= $signed(i_coef) * smp_im;
        if (i_ctl.clear) begin
            r_acc_re <= '0;
            r_acc_im <= '0;
        end else if (r_v2) begin
            r_acc_re <= r_acc_re + ACC_W'(r_prod_re);
            r_acc_im <= r_acc_im + ACC_W'(r_prod_im);
        end
    end

    // round half up, floor shift, saturate
    always_comb begin
        rnd_re  = r_acc_re + ACC_W'(2 ** (FRAC_BITS - 1));
        rnd_im  = r_acc_im + ACC_W'(2 ** (FRAC_BITS - 1));
        q_re    = rnd_re[ACC_W-1:FRAC_BITS];
        q_im    = rnd_im[ACC_W-1:FRAC_BITS];
        clip_re = (q_re[Q_W-1:SMP_W-1] != '0) && (q_re[Q_W-1:SMP_W-1] != '1);
        clip_im = (q_im[Q_W-1:SMP_W-1] != '0) && (q_im[Q_W-1:SMP_W-1] != '1);

        o_res.busy = r_v1 || r_v2;
        o_res.clip = clip_re || clip_im;
        if (clip_re) begin
            o_res.re = q_re[Q_W-1] ? {1'b1, {(SMP_W-1){1'b0}}} : {1'b0, {(SMP_W-1){1'b1}}};
        end else begin
            o_res.re = q_re[SMP_W-1:0];
        end
        if (clip_im) begin
            o_res.im = q_im[Q_W-1] ? {1'b1, {(SMP_W-1){1'b0}}} : {1'b0, {(SMP_W-1){1'b1}}};
        end else begin
            o_res.im = q_im[SMP_W-1:0];
        end
    end

endmodule

`default_nettype wire
